// File: rtl/mbdpe_pkg.sv
// shared constants for the multi-button debounce press event block
package mbdpe_pkg;

  // default number of debounced channels
  localparam int NUM_CHANNELS_DEF = 4;

  // fixed widths of the port fields
  localparam int RAW_BITS   = 4;
  localparam int TIME_W     = 32;
  localparam int DEBOUNCE_W = 16;
  localparam int INDEX_W    = 2;

  // debounce time after reset, in milliseconds
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;

endpackage

// File: rtl/multi_button_debounce_press_event_core.sv
// Multi-button debouncer with press events.
//
// Input channel: in_valid / in_stall carry one poll word, now_ms (free
// running millisecond count) and raw_levels (active-low button pins).
// Output channel: out_valid / out_stall carry one result word per poll,
// press_valid and press_index (lowest button newly pressed, 0 if none).
// Configuration: cfg_write loads cfg_data into the debounce time.
//
// A poll word is captured in an input register and then goes through
// the per-channel compare and update logic into the result register,
// which drives out_valid. One word is accepted every cycle while the
// receiver does not stall; the single compare/update pass sets the rate.
//
// Reset clears all channels to released and unpressed, change times to
// zero and the debounce time to 50. When the receiver stalls, the result
// register holds, the input register keeps one further word, and then
// in_stall rises until the result is taken.
module multi_button_debounce_press_event_core
  import mbdpe_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     now_ms,
  input  logic [RAW_BITS-1:0]   raw_levels,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  press_valid,
  output logic [INDEX_W-1:0]    press_index,
  input  logic                  cfg_write,
  input  logic [DEBOUNCE_W-1:0] cfg_data
);

  // input register
  logic                in_held;
  logic [TIME_W-1:0]   now_reg;
  logic [RAW_BITS-1:0] raw_reg;

  // per-channel state
  logic [NUM_CHANNELS-1:0] last_raw;
  logic [NUM_CHANNELS-1:0] stable_level;
  logic [NUM_CHANNELS-1:0] press_latched;
  logic [TIME_W-1:0]       change_time [NUM_CHANNELS];
  logic [DEBOUNCE_W-1:0]   debounce_time;

  // result register
  logic               res_valid;
  logic               res_press;
  logic [INDEX_W-1:0] res_index;

  // next values
  logic [NUM_CHANNELS-1:0] raw_ext;
  logic [NUM_CHANNELS-1:0] last_raw_next;
  logic [NUM_CHANNELS-1:0] stable_level_next;
  logic [NUM_CHANNELS-1:0] press_latched_next;
  logic [TIME_W-1:0]       change_time_next [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] fire;
  logic [TIME_W-1:0]       held_for [NUM_CHANNELS];
  logic [INDEX_W-1:0]      fire_index;
  logic                    advance;
  logic                    in_take;

  // handshake control
  assign advance  = in_held && (!res_valid || !out_stall);
  assign in_stall = in_held && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid   = res_valid;
  assign press_valid = res_press;
  assign press_index = res_index;

  // channels beyond the pin field read as released
  generate
    if (NUM_CHANNELS <= RAW_BITS) begin : g_raw_narrow
      assign raw_ext = raw_reg[NUM_CHANNELS-1:0];
    end else begin : g_raw_wide
      assign raw_ext = {{(NUM_CHANNELS-RAW_BITS){1'b1}}, raw_reg};
    end
  endgenerate

  // per-channel debounce and press detection
  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      last_raw_next[i]      = raw_ext[i];
      change_time_next[i]   = (raw_ext[i] != last_raw[i]) ? now_reg : change_time[i];
      held_for[i]           = now_reg - change_time_next[i];
      stable_level_next[i]  = stable_level[i];
      press_latched_next[i] = press_latched[i];
      fire[i]               = 1'b0;
      if (held_for[i] >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_time} &&
          stable_level[i] != raw_ext[i]) begin
        stable_level_next[i] = raw_ext[i];
        if (!raw_ext[i] && !press_latched[i]) begin
          press_latched_next[i] = 1'b1;
          fire[i]               = 1'b1;
        end
        if (raw_ext[i]) begin
          press_latched_next[i] = 1'b0;
        end
      end
    end
  end

  // lowest firing channel wins
  always_comb begin
    fire_index = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (fire[i]) begin
        fire_index = INDEX_W'(i);
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_held <= 1'b0;
    end else if (in_take) begin
      in_held <= 1'b1;
    end else if (advance) begin
      in_held <= 1'b0;
    end
    if (in_take) begin
      now_reg <= now_ms;
      raw_reg <= raw_levels;
    end
  end

  // channel state and debounce time
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= '1;
      stable_level  <= '1;
      press_latched <= '0;
      debounce_time <= DEBOUNCE_RESET;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        change_time[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        debounce_time <= cfg_data;
      end
      if (advance) begin
        last_raw      <= last_raw_next;
        stable_level  <= stable_level_next;
        press_latched <= press_latched_next;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          change_time[i] <= change_time_next[i];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!out_stall) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_press <= |fire;
      res_index <= fire_index;
    end
  end

endmodule
